### rtl/core/difficulty_to_target_assert.svh
// Assertion macros for the difficulty to target block.
`ifndef DIFFICULTY_TO_TARGET_ASSERT_SVH
`define DIFFICULTY_TO_TARGET_ASSERT_SVH

`ifndef SYNTHESIS

`define DTT_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`define DTT_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
    else $error(msg);

`else

`define DTT_ASSERT(label, clk, rst_n, ante, cons, msg)

`define DTT_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg)

`endif

`endif

### rtl/core/dtt_pkg.sv
// Shared widths and pipeline stage type for the difficulty to target block.
`default_nettype none

package dtt_pkg;

  localparam int unsigned DIFF_W   = 64;
  localparam int unsigned TARGET_W = 256;
  localparam int unsigned WORD_W   = 64;

  typedef struct packed {
    logic                zero;
    logic                sat;
    logic [DIFF_W-1:0]   d;
    logic [DIFF_W-1:0]   rem;
    logic [TARGET_W-1:0] q;
  } stage_t;

endpackage

`default_nettype wire

### rtl/core/dtt_div_step.sv
// One restoring division stage: produces the quotient bit at position POS, or ORs it into sat when POS >= TARGET_W.
`default_nettype none

module dtt_div_step #(
  parameter int unsigned POS    = 0,
  parameter int unsigned NUM_LO = 240,
  parameter int unsigned NUM_HI = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  dtt_pkg::stage_t stage_i,
  output logic            valid_o,
  output dtt_pkg::stage_t stage_o
);
  import dtt_pkg::*;

  localparam logic NUM_BIT = (POS >= NUM_LO) && (POS <= NUM_HI);
  localparam bit   HIGH    = POS >= TARGET_W;

  logic [DIFF_W-1:0] shifted;
  logic [DIFF_W:0]   diff;
  logic              take;
  stage_t            stage_d;
  stage_t            stage_q;
  logic              valid_q;

  always_comb begin
    shifted = {stage_i.rem[DIFF_W-2:0], NUM_BIT};
    diff    = {stage_i.rem[DIFF_W-1], shifted} - {1'b0, stage_i.d};
    take    = ~diff[DIFF_W];
    stage_d = stage_i;
    stage_d.rem = take ? diff[DIFF_W-1:0] : shifted;
    if (HIGH) begin
      stage_d.sat = stage_i.sat | take;
    end else begin
      stage_d.q = {stage_i.q[TARGET_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

### rtl/core/dtt_out.sv
// Output stage: clamps the quotient and drives the result beat.
`default_nettype none

module dtt_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  dtt_pkg::stage_t            stage_i,
  output logic                       done_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word0_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word1_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word2_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word3_o,
  output logic                       zero_difficulty_o,
  output logic                       saturated_o
);
  import dtt_pkg::*;

  logic [TARGET_W-1:0] target_d;
  logic [TARGET_W-1:0] target_q;
  logic                zero_q;
  logic                sat_q;
  logic                done_q;

  always_comb begin
    if (stage_i.zero || stage_i.sat) begin
      target_d = '1;
    end else begin
      target_d = stage_i.q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      target_q <= target_d;
      zero_q   <= stage_i.zero;
      sat_q    <= stage_i.sat & ~stage_i.zero;
    end
  end

  assign done_o            = done_q;
  assign target_word0_o    = target_q[0*WORD_W +: WORD_W];
  assign target_word1_o    = target_q[1*WORD_W +: WORD_W];
  assign target_word2_o    = target_q[2*WORD_W +: WORD_W];
  assign target_word3_o    = target_q[3*WORD_W +: WORD_W];
  assign zero_difficulty_o = zero_q;
  assign saturated_o       = sat_q;

endmodule

`default_nettype wire

### rtl/core/difficulty_to_target.sv
// Top level: difficulty to 256-bit target through a pipelined long divider.
//
// A difficulty with FRAC_BITS fraction bits is taken whenever start_i is high
// (busy_o stays low, one item per cycle) and its target
// floor(0xFFFF * 2^208 / difficulty) appears for one cycle, marked by done_o,
// least significant word in target_word0_o. The target passes through an
// input register, the restoring divider (one 65-bit subtract and one
// quotient bit per pipeline stage, 224 + FRAC_BITS stages, those above bit
// 255 feeding saturated_o) and an output register. Results cannot be held
// off; every accepted difficulty gives exactly one done_o beat, in order.
// A zero difficulty gives all ones with zero_difficulty_o; a quotient of 2^256
// or more gives all ones with saturated_o.
`default_nettype none

`include "difficulty_to_target_assert.svh"

module difficulty_to_target #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [dtt_pkg::DIFF_W-1:0] difficulty_i,
  output logic                       done_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word0_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word1_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word2_o,
  output logic [dtt_pkg::WORD_W-1:0] target_word3_o,
  output logic                       zero_difficulty_o,
  output logic                       saturated_o
);
  import dtt_pkg::*;

  localparam int unsigned NUM_LO  = 208 + FRAC_BITS;
  localparam int unsigned NUM_HI  = 223 + FRAC_BITS;
  localparam int unsigned STAGES  = NUM_HI + 1;
  localparam int unsigned LATENCY = STAGES + 2;

  logic   accept;
  logic   valid [0:STAGES];
  stage_t stg   [0:STAGES];
  logic   in_valid_q;
  stage_t in_stage_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_stage_q.zero <= (difficulty_i == '0);
      in_stage_q.sat  <= 1'b0;
      in_stage_q.d    <= difficulty_i;
      in_stage_q.rem  <= '0;
      in_stage_q.q    <= '0;
    end
  end

  assign valid[0] = in_valid_q;
  assign stg[0]   = in_stage_q;

  for (genvar i = 0; i < STAGES; i++) begin : g_step
    dtt_div_step #(
      .POS    (STAGES - 1 - i),
      .NUM_LO (NUM_LO),
      .NUM_HI (NUM_HI)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .stage_i (stg[i]),
      .valid_o (valid[i+1]),
      .stage_o (stg[i+1])
    );
  end

  dtt_out u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (valid[STAGES]),
    .stage_i           (stg[STAGES]),
    .done_o            (done_o),
    .target_word0_o    (target_word0_o),
    .target_word1_o    (target_word1_o),
    .target_word2_o    (target_word2_o),
    .target_word3_o    (target_word3_o),
    .zero_difficulty_o (zero_difficulty_o),
    .saturated_o       (saturated_o)
  );

  `DTT_ASSERT_DLY(a_latency, clk_i, rst_ni, accept, LATENCY, done_o, "beat lost in pipeline")
  `DTT_ASSERT(a_no_phantom, clk_i, rst_ni, done_o, $past(accept, LATENCY), "phantom beat")
  `DTT_ASSERT(a_flags_excl, clk_i, rst_ni, done_o, !(zero_difficulty_o && saturated_o), "both flags")
  `DTT_ASSERT(a_sat_ones, clk_i, rst_ni, done_o && saturated_o, target_word3_o == '1, "sat not clamped")

endmodule

`default_nettype wire
